@@ rtl/tfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Texel format packer package
// Shared format codes, widths and the structs passed between the modules.
// ----------------------------------------------------------------------------
package tfp_pkg;

   // Texel format codes held in the format register.
   typedef enum logic [3:0] {
      FMT_RGBA8888 = 4'd0,
      FMT_RGBA5551 = 4'd1,
      FMT_CI8      = 4'd2,
      FMT_CI4      = 4'd3,
      FMT_I8       = 4'd4,
      FMT_I4       = 4'd5,
      FMT_IA88     = 4'd6,
      FMT_IA8      = 4'd7,
      FMT_IA4      = 4'd8
   } fmt_type;

   localparam logic [3:0] FMT_RESET = FMT_RGBA5551;

   // Register file geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_TEXEL_FORMAT = 1'b0;

   // Byte counts of the result word.
   localparam logic [2:0] BYTES_ONE  = 3'd1;
   localparam logic [2:0] BYTES_TWO  = 3'd2;
   localparam logic [2:0] BYTES_FOUR = 3'd4;

   // Control from the register file to the packing stage.
   typedef struct packed {
      logic [3:0] texel_format;
      logic       format_write;
   } csr_ctrl_type;

   // One packed result leaving the packing stage.
   typedef struct packed {
      logic        valid;
      logic [31:0] packed_word;
      logic [2:0]  byte_count;
      logic        index_error;
      logic        image_done;
   } pack_result_type;

   // Status visible to the top level.
   typedef struct packed {
      logic s1_valid;
      logic pair_pending;
   } pack_status_type;

endpackage

@@ rtl/tfp_csr.sv @@
// ----------------------------------------------------------------------------
// Texel format packer register file
// APB-style access to the texel format register.
// ----------------------------------------------------------------------------
module tfp_csr
   import tfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output csr_ctrl_type          ctrl
);

   logic       wr_en;
   logic [3:0] texel_format_ff;
   logic [3:0] texel_format_in;

   // A write completes in the access phase; the word index is the upper address bit.
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[CSR_ADDR_W-1] == REG_TEXEL_FORMAT);

   always_comb begin
      texel_format_in = texel_format_ff;
      if (wr_en) begin
         texel_format_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_format_ff <= FMT_RESET;
      end else begin
         texel_format_ff <= texel_format_in;
      end
   end

   // Read data decode.
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_TEXEL_FORMAT: csr_prdata = {{(CSR_DATA_W-4){1'b0}}, texel_format_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign ctrl.texel_format = texel_format_ff;
   assign ctrl.format_write = wr_en;

endmodule

@@ rtl/tfp_pack.sv @@
// ----------------------------------------------------------------------------
// Texel format packer stage
// Input register, format conversion and the nibble pairing state.
// ----------------------------------------------------------------------------
module tfp_pack
   import tfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csr_ctrl_type    ctrl,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_chan_a,
   input  logic [7:0]      req_chan_b,
   input  logic [7:0]      req_chan_c,
   input  logic [7:0]      req_chan_d,
   input  logic            req_end_of_image,
   input  logic            advance,
   output pack_result_type result,
   output pack_status_type status
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] chan_a_ff, chan_b_ff, chan_c_ff, chan_d_ff;
   logic       eoi_ff;
   logic       pair_pending_ff, pair_pending_in;
   logic [3:0] held_nibble_ff, held_nibble_in;
   logic       held_error_ff, held_error_in;
   logic       take;
   logic       is_nibble;
   logic [3:0] nib;
   logic       nib_err;

   // The input register refills whenever its transaction moves on.
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign s1_valid_in = take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         chan_a_ff <= req_chan_a;
         chan_b_ff <= req_chan_b;
         chan_c_ff <= req_chan_c;
         chan_d_ff <= req_chan_d;
         eoi_ff    <= req_end_of_image;
      end
   end

   // Nibble of the current pixel for the 4-bit formats.
   always_comb begin
      nib       = '0;
      nib_err   = 1'b0;
      is_nibble = 1'b0;
      case (ctrl.texel_format)
         FMT_CI4: begin
            nib       = chan_a_ff[3:0];
            nib_err   = |chan_a_ff[7:4];
            is_nibble = 1'b1;
         end
         FMT_I4: begin
            nib       = chan_a_ff[7:4];
            is_nibble = 1'b1;
         end
         FMT_IA4: begin
            nib       = {chan_a_ff[7:5], |chan_b_ff};
            is_nibble = 1'b1;
         end
         default: begin
            nib       = '0;
            nib_err   = 1'b0;
            is_nibble = 1'b0;
         end
      endcase
   end

   // Format conversion and pairing of 4-bit pixels.
   always_comb begin
      result.valid       = 1'b0;
      result.packed_word = '0;
      result.byte_count  = BYTES_ONE;
      result.index_error = 1'b0;
      result.image_done  = eoi_ff;
      pair_pending_in    = pair_pending_ff;
      held_nibble_in     = held_nibble_ff;
      held_error_in      = held_error_ff;

      case (ctrl.texel_format)
         FMT_RGBA8888: begin
            result.valid       = 1'b1;
            result.packed_word = {chan_a_ff, chan_b_ff, chan_c_ff, chan_d_ff};
            result.byte_count  = BYTES_FOUR;
         end
         FMT_RGBA5551: begin
            result.valid       = 1'b1;
            result.packed_word = {16'd0, chan_a_ff[7:3], chan_b_ff[7:3],
                                  chan_c_ff[7:3], |chan_d_ff};
            result.byte_count  = BYTES_TWO;
         end
         FMT_CI8, FMT_I8: begin
            result.valid       = 1'b1;
            result.packed_word = {24'd0, chan_a_ff};
         end
         FMT_IA88: begin
            result.valid       = 1'b1;
            result.packed_word = {16'd0, chan_a_ff, chan_b_ff};
            result.byte_count  = BYTES_TWO;
         end
         FMT_IA8: begin
            result.valid       = 1'b1;
            result.packed_word = {24'd0, chan_a_ff[7:4], chan_b_ff[7:4]};
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase

      if (is_nibble) begin
         if (pair_pending_ff) begin
            // Second pixel of a pair completes the byte.
            result.valid       = 1'b1;
            result.packed_word = {24'd0, held_nibble_ff, nib};
            result.index_error = nib_err | held_error_ff;
            pair_pending_in    = 1'b0;
            held_nibble_in     = '0;
            held_error_in      = 1'b0;
         end else if (eoi_ff) begin
            // Odd pixel count: the last pixel goes out with a zero partner.
            result.valid       = 1'b1;
            result.packed_word = {24'd0, nib, 4'd0};
            result.index_error = nib_err;
         end else begin
            pair_pending_in = 1'b1;
            held_nibble_in  = nib;
            held_error_in   = nib_err;
         end
      end

      // Only a pixel held in the input register produces a result.
      result.valid = result.valid && s1_valid_ff;
   end

   // Pairing state; a format write drops any held pixel.
   always_ff @(posedge clock) begin
      if (reset || ctrl.format_write) begin
         pair_pending_ff <= 1'b0;
         held_nibble_ff  <= '0;
         held_error_ff   <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         pair_pending_ff <= pair_pending_in;
         held_nibble_ff  <= held_nibble_in;
         held_error_ff   <= held_error_in;
      end
   end

   assign status.s1_valid     = s1_valid_ff;
   assign status.pair_pending = pair_pending_ff;

endmodule

@@ rtl/texel_format_packer_core.sv @@
// A pixel taken passes through the input register, then the result register, to the
// rsp ports. Throughput: one pixel per cycle while the result is not stalled;
// the first pixel of a 4-bit pair gives no result.
// A pixel is taken while a result waits only if the input register is empty; with
// both registers full, the result stall reaches req_stall in the same cycle.
// Reset is synchronous and active high; it clears valids, the pairing state and
// sets the texel format to RGBA16.
// ----------------------------------------------------------------------------
// Texel format packer core
// Packs one pixel per transaction into the configured texel format.
// ----------------------------------------------------------------------------
module texel_format_packer_core
   import tfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_chan_a,
   input  logic [7:0]            req_chan_b,
   input  logic [7:0]            req_chan_c,
   input  logic [7:0]            req_chan_d,
   input  logic                  req_end_of_image,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_packed_word,
   output logic [2:0]            rsp_byte_count,
   output logic                  rsp_index_error,
   output logic                  rsp_image_done,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_ctrl_type    ctrl;
   pack_result_type result;
   pack_status_type status;
   logic            advance;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     packed_word_ff;
   logic [2:0]      byte_count_ff;
   logic            index_error_ff;
   logic            image_done_ff;

   tfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctrl        (ctrl)
   );

   tfp_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_chan_a       (req_chan_a),
      .req_chan_b       (req_chan_b),
      .req_chan_c       (req_chan_c),
      .req_chan_d       (req_chan_d),
      .req_end_of_image (req_end_of_image),
      .advance          (advance),
      .result           (result),
      .status           (status)
   );

   // The result register loads whenever it is empty or being drained.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = advance ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         packed_word_ff <= result.packed_word;
         byte_count_ff  <= result.byte_count;
         index_error_ff <= result.index_error;
         image_done_ff  <= result.image_done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_word = packed_word_ff;
   assign rsp_byte_count  = byte_count_ff;
   assign rsp_index_error = index_error_ff;
   assign rsp_image_done  = image_done_ff;

`ifndef SYNTHESIS
   // Input backpressure only when the input stage is full and the result is blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (status.s1_valid && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // A format write always drops a held pixel.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.format_write |=> !status.pair_pending)
      else $error("held pixel survived a format write");

   // Index errors only come with single-byte results.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_index_error) |-> (rsp_byte_count == BYTES_ONE))
      else $error("index error on a multi-byte result");

   // Byte count is always one, two or four.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_byte_count == BYTES_ONE || rsp_byte_count == BYTES_TWO ||
                        rsp_byte_count == BYTES_FOUR))
      else $error("illegal byte count");
`endif

endmodule

@@ bench/tb_texel_format_packer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Texel format packer core testbench
// Streams pixels through every texel format, including the unknown format
// codes, and checks each packed texel against a behavioral packer kept in a
// small scoreboard. The format register is rewritten between phases while
// the core is idle, and both channels see random idle cycles and stalls.
// ----------------------------------------------------------------------------
module tb_texel_format_packer_core;
   import tfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PIXELS  = 1100;
   localparam int SETTLE_CYCLES  = 6;
   localparam logic [CSR_ADDR_W-1:0] TEXEL_FORMAT_ADDR = CSR_ADDR_W'(4 * REG_TEXEL_FORMAT);

   // One packed texel as seen on the result channel.
   typedef struct packed {
      logic [31:0] packed_word;
      logic [2:0]  byte_count;
      logic        index_error;
      logic        image_done;
   } texel_word_type;

   // Behavioral packer and the queue of texels it still expects.
   class texel_pack_tracker_type;
      logic [3:0]     texel_format;
      logic           pair_pending;
      logic [3:0]     held_nibble;
      logic           held_error;
      texel_word_type expected_texels[$];
      int             mismatches;

      function new();
         texel_format = FMT_RESET;
         pair_pending = 1'b0;
         held_nibble  = 4'd0;
         held_error   = 1'b0;
         mismatches   = 0;
      endfunction

      // Any format write drops a held half-pair.
      function void set_format(logic [3:0] code);
         texel_format = code;
         pair_pending = 1'b0;
         held_nibble  = 4'd0;
         held_error   = 1'b0;
      endfunction

      function int outstanding();
         return expected_texels.size();
      endfunction

      task report_mismatch(string msg);
         $display("%0t: mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Work out what one accepted pixel produces, if anything.
      function void note_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                               logic eoi);
         texel_word_type texel;
         logic [3:0]     nibble;
         logic           bad_index;
         texel             = '0;
         texel.byte_count  = BYTES_ONE;
         texel.image_done  = eoi;
         bad_index         = 1'b0;
         case (texel_format)
            FMT_RGBA8888: begin
               texel.packed_word = {a, b, c, d};
               texel.byte_count  = BYTES_FOUR;
            end
            FMT_RGBA5551: begin
               texel.packed_word = {16'd0, a[7:3], b[7:3], c[7:3], d != 8'd0};
               texel.byte_count  = BYTES_TWO;
            end
            FMT_CI8, FMT_I8: begin
               texel.packed_word = {24'd0, a};
            end
            FMT_IA88: begin
               texel.packed_word = {16'd0, a, b};
               texel.byte_count  = BYTES_TWO;
            end
            FMT_IA8: begin
               texel.packed_word = {24'd0, a[7:4], b[7:4]};
            end
            FMT_CI4, FMT_I4, FMT_IA4: begin
               if (texel_format == FMT_CI4) begin
                  nibble    = a[3:0];
                  bad_index = a[7:4] != 4'd0;
               end else if (texel_format == FMT_I4) begin
                  nibble = a[7:4];
               end else begin
                  nibble = {a[7:5], b != 8'd0};
               end
               if (pair_pending) begin
                  texel.packed_word = {24'd0, held_nibble, nibble};
                  texel.index_error = bad_index | held_error;
                  pair_pending      = 1'b0;
                  held_nibble       = 4'd0;
                  held_error        = 1'b0;
               end else if (eoi) begin
                  // Odd pixel count: the lone nibble goes out with a zero partner.
                  texel.packed_word = {24'd0, nibble, 4'd0};
                  texel.index_error = bad_index;
               end else begin
                  pair_pending = 1'b1;
                  held_nibble  = nibble;
                  held_error   = bad_index;
                  return;
               end
            end
            default: begin
               // Unknown format codes drop the pixel.
               return;
            end
         endcase
         expected_texels.push_back(texel);
      endfunction

      // Compare one accepted texel with the oldest expected one.
      task check_texel(texel_word_type got);
         texel_word_type want;
         if (expected_texels.size() == 0) begin
            report_mismatch($sformatf("unexpected texel word %h", got.packed_word));
            return;
         end
         want = expected_texels.pop_front();
         if (got.packed_word !== want.packed_word)
            report_mismatch($sformatf("packed_word %h, expected %h",
                                      got.packed_word, want.packed_word));
         if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      got.byte_count, want.byte_count));
         if (got.index_error !== want.index_error)
            report_mismatch($sformatf("index_error %b, expected %b",
                                      got.index_error, want.index_error));
         if (got.image_done !== want.image_done)
            report_mismatch($sformatf("image_done %b, expected %b",
                                      got.image_done, want.image_done));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_chan_a;
   logic [7:0]            req_chan_b;
   logic [7:0]            req_chan_c;
   logic [7:0]            req_chan_d;
   logic                  req_end_of_image;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [31:0]           rsp_packed_word;
   logic [2:0]            rsp_byte_count;
   logic                  rsp_index_error;
   logic                  rsp_image_done;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   texel_pack_tracker_type tracker;
   bit                     steady_sender;
   int                     idle_cycles;

   texel_format_packer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_chan_a       (req_chan_a),
      .req_chan_b       (req_chan_b),
      .req_chan_c       (req_chan_c),
      .req_chan_d       (req_chan_d),
      .req_end_of_image (req_end_of_image),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_word  (rsp_packed_word),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_index_error  (rsp_index_error),
      .rsp_image_done   (rsp_image_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle time before a pixel: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      if (steady_sender)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Channel value leaning toward the extremes.
   function automatic logic [7:0] pick_channel();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return 8'h00;
      if (roll == 1)
         return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one pixel and wait until the core takes it.
   task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input logic eoi);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_chan_a       <= a;
      req_chan_b       <= b;
      req_chan_c       <= c;
      req_chan_d       <= d;
      req_end_of_image <= eoi;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.note_pixel(a, b, c, d, eoi);
   endtask

   // Stop offering pixels and wait for the core to drain.
   task automatic drain_core();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register transaction: setup cycle, then access cycle. Starts at a falling edge.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= TEXEL_FORMAT_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Change the texel format while idle and read it back.
   task automatic program_format(input logic [3:0] code);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      drain_core();
      wdata = {28'($urandom()), code};
      csr_access(1'b1, wdata, rdata);
      tracker.set_format(code);
      csr_access(1'b0, '0, rdata);
      if (rdata !== {28'd0, code})
         tracker.report_mismatch($sformatf("texel_format read %h, expected %h", rdata, code));
   endtask

   // Receiver: free stretches broken by stalls, mostly short.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = $urandom_range(1, 20);
         if ($urandom_range(0, 9) == 0)
            run = $urandom_range(50, 150);
         @(negedge clock);
         rsp_stall <= 1'b0;
         repeat (run - 1) @(negedge clock);
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
         @(negedge clock);
         rsp_stall <= 1'b1;
         repeat (run - 1) @(negedge clock);
      end
   end

   // Check every texel the receiver accepts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_texel({rsp_packed_word, rsp_byte_count, rsp_index_error, rsp_image_done});
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, directed pixels, random phases, drain and verdict.
   initial begin
      logic [3:0] code;
      logic [7:0] index;
      int         phase_len;
      int         counted;
      tracker          = new();
      steady_sender    = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_chan_a       = 8'd0;
      req_chan_b       = 8'd0;
      req_chan_c       = 8'd0;
      req_chan_d       = 8'd0;
      req_end_of_image = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // RGBA16 straight out of reset: extremes and the one-bit alpha.
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h08, 8'h10, 8'hF8, 8'h01, 1'b1);

      program_format(FMT_RGBA8888);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

      program_format(FMT_CI8);
      send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);

      // CI4: index too large in either half, and an odd count ending in a bad index.
      program_format(FMT_CI4);
      send_pixel(8'h05, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h10, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h03, 8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'h14, 8'h00, 8'h00, 8'h00, 1'b1);

      // A format write, even to the same code, drops the held half-pair.
      send_pixel(8'h0A, 8'h00, 8'h00, 8'h00, 1'b0);
      program_format(FMT_CI4);
      send_pixel(8'h06, 8'h00, 8'h00, 8'h00, 1'b1);

      program_format(FMT_I8);
      send_pixel(8'hAB, 8'h00, 8'h00, 8'h00, 1'b1);

      program_format(FMT_I4);
      send_pixel(8'hF0, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h1F, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h80, 8'h00, 8'h00, 8'h00, 1'b1);

      program_format(FMT_IA88);
      send_pixel(8'hAB, 8'hCD, 8'h00, 8'h00, 1'b1);

      program_format(FMT_IA8);
      send_pixel(8'hFE, 8'h7F, 8'h00, 8'h00, 1'b1);

      program_format(FMT_IA4);
      send_pixel(8'hE0, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h20, 8'h01, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);

      // Highest unknown code: the pixel is dropped.
      program_format(4'hF);
      send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);

      // Random phases, each under one format; unknown codes now and then.
      counted = 0;
      while (counted < RANDOM_PIXELS) begin
         if ($urandom_range(0, 19) == 0)
            code = 4'($urandom_range(9, 15));
         else
            code = 4'($urandom_range(0, 8));
         program_format(code);
         steady_sender = ($urandom_range(0, 4) == 0);
         phase_len     = $urandom_range(5, 60);
         repeat (phase_len) begin
            index = pick_channel();
            if (code == FMT_CI4 && $urandom_range(0, 3) != 0)
               index = 8'($urandom_range(0, 15));
            send_pixel(index, pick_channel(), pick_channel(), pick_channel(),
                       $urandom_range(0, 7) == 0);
         end
         steady_sender = 1'b0;
         if (code <= FMT_IA4)
            counted += phase_len;
      end

      drain_core();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
